>>> rtl/core/ofd_pkg.sv
// ----------------------------------------------------------------------------
// Optical flow frame decoder package
// Shared constants, register indexes and beat types for the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ofd_pkg;

  // Frame header and flag byte position
  localparam logic [7:0] HDR_FIRST  = 8'hFE;
  localparam logic [7:0] HDR_SECOND = 8'h0A;
  localparam int unsigned FLAG_BYTE = 8;

  // Configuration register widths and reset values
  localparam int unsigned DB_W  = 15;
  localparam int unsigned LIM_W = 16;
  localparam logic [DB_W-1:0]  DEADBAND_RST = 15'd24;
  localparam logic [LIM_W-1:0] LOW_LIM_RST  = 16'd80;
  localparam logic [LIM_W-1:0] MID_LIM_RST  = 16'd130;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEADBAND = 2'd0,
    CFG_LOW_LIM  = 2'd1,
    CFG_MID_LIM  = 2'd2
  } cfg_idx_t;

  // Height buckets
  localparam logic [7:0] SCALE_LOW  = 8'd100;
  localparam logic [7:0] SCALE_MID  = 8'd160;
  localparam logic [7:0] SCALE_HIGH = 8'd220;

  // Good-frame event from the parser
  typedef struct packed {
    logic               good;
    logic               upd;
    logic signed [15:0] raw_x;
    logic signed [15:0] raw_y;
  } frame_t;

  // One result beat
  typedef struct packed {
    logic signed [15:0] flow_x_filtered;
    logic signed [15:0] flow_y_filtered;
    logic [7:0]         height_scale;
    logic signed [23:0] flow_x_scaled;
    logic signed [23:0] flow_y_scaled;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/core/ofd_if.sv
// ----------------------------------------------------------------------------
// Optical flow frame decoder channels
// Valid/ready channels for input bytes, result beats and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface ofd_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  rx_byte;
  logic [15:0] altitude_cm;

  modport source (output valid, output rx_byte, output altitude_cm, input ready);
  modport sink   (input valid, input rx_byte, input altitude_cm, output ready);
endinterface

interface ofd_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] flow_x_filtered;
  logic signed [15:0] flow_y_filtered;
  logic [7:0]         height_scale;
  logic signed [23:0] flow_x_scaled;
  logic signed [23:0] flow_y_scaled;

  modport source (output valid, output flow_x_filtered, output flow_y_filtered,
                  output height_scale, output flow_x_scaled, output flow_y_scaled,
                  input ready);
  modport sink   (input valid, input flow_x_filtered, input flow_y_filtered,
                  input height_scale, input flow_x_scaled, input flow_y_scaled,
                  output ready);
endinterface

interface ofd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/ofd_parser.sv
// ----------------------------------------------------------------------------
// Optical flow frame parser
// Hunts for the header, stores the payload and checks the XOR checksum.
// ----------------------------------------------------------------------------
`default_nettype none

module ofd_parser
  import ofd_pkg::*;
#(
  parameter int unsigned PAYLOAD_LEN = 10
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic [7:0] rx_byte,
  output frame_t          frame
);

  localparam int unsigned CNT_W = $clog2(PAYLOAD_LEN + 1);
  localparam int unsigned IDX_W = $clog2(PAYLOAD_LEN);
  localparam logic [CNT_W-1:0] LEN = CNT_W'(PAYLOAD_LEN);

  typedef enum logic [2:0] {
    PH_HUNT = 3'b001,
    PH_HDR  = 3'b010,
    PH_BODY = 3'b100
  } phase_t;

  phase_t           phase_r, phase_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [7:0]       store_r [PAYLOAD_LEN];
  logic             store_we;

  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r;
    sum_nxt    = sum_r;
    store_we   = 1'b0;
    frame.good = 1'b0;
    case (phase_r)
      PH_HUNT: begin
        if (rx_byte == HDR_FIRST) phase_nxt = PH_HDR;
      end
      PH_HDR: begin
        // a repeated first header byte is not a new header
        phase_nxt = (rx_byte == HDR_SECOND) ? PH_BODY : PH_HUNT;
        sum_nxt   = '0;
      end
      PH_BODY: begin
        if (cnt_r < LEN) begin
          store_we = 1'b1;
          cnt_nxt  = cnt_r + 1'b1;
          sum_nxt  = sum_r ^ rx_byte;
        end else begin
          frame.good = (sum_r == rx_byte);
          cnt_nxt    = '0;
          phase_nxt  = PH_HUNT;
        end
      end
      default: begin
        phase_nxt = PH_HUNT;
        cnt_nxt   = '0;
      end
    endcase
    frame.good  = frame.good & accept;
    frame.upd   = (store_r[FLAG_BYTE] != 8'd0);
    frame.raw_x = $signed({store_r[1], store_r[0]});
    frame.raw_y = $signed({store_r[3], store_r[2]});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      cnt_r   <= '0;
      sum_r   <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && store_we) store_r[cnt_r[IDX_W-1:0]] <= rx_byte;
  end

endmodule

`default_nettype wire

>>> rtl/core/optical_flow_frame_decoder_unit.sv
// ----------------------------------------------------------------------------
// Optical flow frame decoder unit
// Parses sensor frames, then median, deadband and height scaling per axis.
// ----------------------------------------------------------------------------
// The result of a good frame is registered into the output register when its
//   checksum beat is accepted and that register is free, else into the skid stage.
// Throughput: one input beat per cycle; the output register plus a one-beat
//   skid stage keep input flowing while a result waits to be taken, and input
//   stalls only while both of them hold a beat.
// Reset (rst_n low, synchronous): parser back to header hunt, held flow and
//   median fill cleared, registers to deadband 24 and limits 80/130.
// ----------------------------------------------------------------------------
`default_nettype none

module optical_flow_frame_decoder_unit
  import ofd_pkg::*;
#(
  parameter int unsigned PAYLOAD_LEN = 10
) (
  input wire logic  clk,
  input wire logic  rst_n,
  ofd_in_if.sink    in_ch,
  ofd_out_if.source out_ch,
  ofd_cfg_if.sink   cfg_ch
);

  // --------------------------------------------------------------------------
  // Configuration registers: take a write on every cfg beat, drop unknown
  // indexes.
  // --------------------------------------------------------------------------
  logic [DB_W-1:0]  deadband_r;
  logic [LIM_W-1:0] low_lim_r;
  logic [LIM_W-1:0] mid_lim_r;
  logic             cfg_fire;

  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid && cfg_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadband_r <= DEADBAND_RST;
      low_lim_r  <= LOW_LIM_RST;
      mid_lim_r  <= MID_LIM_RST;
    end else if (cfg_fire) begin
      case (cfg_idx_t'(cfg_ch.index))
        CFG_DEADBAND: deadband_r <= cfg_ch.data[DB_W-1:0];
        CFG_LOW_LIM:  low_lim_r  <= cfg_ch.data[LIM_W-1:0];
        CFG_MID_LIM:  mid_lim_r  <= cfg_ch.data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake: accept input whenever the skid stage is free.
  // --------------------------------------------------------------------------
  logic    out_valid_r, out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t out_r, out_nxt;
  result_t skid_r, skid_nxt;
  logic    in_fire;
  logic    out_fire;
  frame_t  frame;

  assign in_ch.ready = !skid_valid_r;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_valid_r && out_ch.ready;

  ofd_parser #(
    .PAYLOAD_LEN (PAYLOAD_LEN)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_fire),
    .rx_byte (in_ch.rx_byte),
    .frame   (frame)
  );

  // --------------------------------------------------------------------------
  // Filter state: held flow, three-entry median windows, fill tracking.
  // --------------------------------------------------------------------------
  logic signed [15:0] held_x_r, held_y_r;
  logic signed [15:0] win_x_r [3];
  logic signed [15:0] win_y_r [3];
  logic [1:0]         slot_r, slot_nxt;
  logic               full_r, full_nxt;

  function automatic logic signed [15:0] median3(input logic signed [15:0] a,
                                                 input logic signed [15:0] b,
                                                 input logic signed [15:0] c);
    logic signed [15:0] lo;
    logic signed [15:0] hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c <= lo)      median3 = lo;
    else if (c >= hi) median3 = hi;
    else              median3 = c;
  endfunction

  function automatic logic signed [15:0] dead_zone(input logic signed [15:0] v,
                                                   input logic [DB_W-1:0]    db);
    logic signed [16:0] v_ext;
    logic signed [16:0] db_pos;
    v_ext  = 17'(v);
    db_pos = $signed({2'b00, db});
    dead_zone = (v_ext < db_pos && v_ext > -db_pos) ? 16'sd0 : v;
  endfunction

  logic signed [15:0] fx_in, fy_in;
  logic signed [15:0] wx [3];
  logic signed [15:0] wy [3];
  logic signed [15:0] fx_med, fy_med;
  logic signed [15:0] fx_out, fy_out;
  logic [7:0]         scale;
  logic signed [24:0] prod_x, prod_y;
  result_t            res;

  always_comb begin
    // a frame with a clear flag byte feeds the last output again
    fx_in = frame.upd ? frame.raw_x : held_x_r;
    fy_in = frame.upd ? frame.raw_y : held_y_r;
    for (int i = 0; i < 3; i++) begin
      wx[i] = (slot_r == 2'(i)) ? fx_in : win_x_r[i];
      wy[i] = (slot_r == 2'(i)) ? fy_in : win_y_r[i];
    end
    full_nxt = full_r || (slot_r == 2'd2);
    slot_nxt = (slot_r == 2'd2) ? 2'd0 : slot_r + 2'd1;
    // pass through until the window has seen three frames
    fx_med = full_nxt ? median3(wx[0], wx[1], wx[2]) : fx_in;
    fy_med = full_nxt ? median3(wy[0], wy[1], wy[2]) : fy_in;
    fx_out = dead_zone(fx_med, deadband_r);
    fy_out = dead_zone(fy_med, deadband_r);

    if (in_ch.altitude_cm < low_lim_r)      scale = SCALE_LOW;
    else if (in_ch.altitude_cm < mid_lim_r) scale = SCALE_MID;
    else                                    scale = SCALE_HIGH;

    prod_x = 25'(fx_out) * 25'($signed({1'b0, scale}));
    prod_y = 25'(fy_out) * 25'($signed({1'b0, scale}));

    res.flow_x_filtered = fx_out;
    res.flow_y_filtered = fy_out;
    res.height_scale    = scale;
    res.flow_x_scaled   = prod_x[23:0];
    res.flow_y_scaled   = prod_y[23:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_x_r <= '0;
      held_y_r <= '0;
      slot_r   <= '0;
      full_r   <= 1'b0;
    end else if (frame.good) begin
      held_x_r <= fx_out;
      held_y_r <= fy_out;
      slot_r   <= slot_nxt;
      full_r   <= full_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (frame.good) begin
      win_x_r[slot_r] <= fx_in;
      win_y_r[slot_r] <= fy_in;
    end
  end

  // --------------------------------------------------------------------------
  // Output register and skid stage: advance the skid beat when the output
  // register drains, park a new result in the skid when the output register stays full.
  // --------------------------------------------------------------------------
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (out_fire) begin
      out_valid_nxt  = skid_valid_r;
      out_nxt        = skid_r;
      skid_valid_nxt = 1'b0;
    end
    if (frame.good) begin
      if (!out_valid_nxt) begin
        out_valid_nxt = 1'b1;
        out_nxt       = res;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_nxt       = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.flow_x_filtered = out_r.flow_x_filtered;
  assign out_ch.flow_y_filtered = out_r.flow_y_filtered;
  assign out_ch.height_scale    = out_r.height_scale;
  assign out_ch.flow_x_scaled   = out_r.flow_x_scaled;
  assign out_ch.flow_y_scaled   = out_r.flow_y_scaled;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid stage holds a beat while the output register is empty");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> out_valid_r)
    else $error("pending result beat lost");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r != 2'd3)
    else $error("median window slot out of range");

  a_full_after_third: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(full_r) |-> ($past(slot_r) == 2'd2 && slot_r == 2'd0))
    else $error("median window marked full before three frames");

  a_scale_bucket: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.height_scale == SCALE_LOW ||
                     out_r.height_scale == SCALE_MID ||
                     out_r.height_scale == SCALE_HIGH))
    else $error("height scale is not a known bucket");

endmodule

`default_nettype wire
